/* src/a2n_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package a2n_pkg;

    // fixed field widths
    localparam int PIX_W  = 32;
    localparam int CFG_W  = 13;
    localparam int IDX_W  = 2;
    localparam int ADDR_W = 25;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;

    // stream packing
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;

    // defaults handed to the top level
    localparam int MAX_DIMENSION_DEF = 4096;
    localparam int FIFO_DEPTH_DEF    = 4;

    // frame size after reset
    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;

    // bt.601 studio range coefficients
    localparam int COEF_YR = 66;
    localparam int COEF_YG = 129;
    localparam int COEF_YB = 25;
    localparam int COEF_UR = 38;
    localparam int COEF_UG = 74;
    localparam int COEF_UB = 112;
    localparam int COEF_VR = 112;
    localparam int COEF_VG = 94;
    localparam int COEF_VB = 18;
    localparam int ROUND_BIAS  = 128;
    localparam int LUMA_OFFSET = 16;
    // rounding term plus 128 << 8, keeps the chroma sum non-negative
    localparam int CHROMA_BIAS = 32768 + ROUND_BIAS;

    typedef enum logic [IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_Y = 2'd0,
        KIND_V = 2'd1,
        KIND_U = 2'd2
    } kind_t;

    // one converted pixel waiting for the output side
    typedef struct packed {
        logic [BYTE_W-1:0] y_byte;
        logic [BYTE_W-1:0] v_byte;
        logic [BYTE_W-1:0] u_byte;
        logic [ADDR_W-1:0] luma_addr;
        logic [ADDR_W-1:0] chroma_addr;
        logic              chroma;
        logic              last_px;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

`default_nettype wire

/* src/a2n_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module a2n_fifo #(
    parameter int DEPTH = a2n_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire a2n_pkg::entry_t     push_entry,
    input  wire logic                pop,
    output a2n_pkg::entry_t          head_entry,
    output a2n_pkg::fifo_stat_t      stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    a2n_pkg::entry_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_entry = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

/* src/a2n_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module a2n_front #(
    parameter int MAX_DIMENSION = a2n_pkg::MAX_DIMENSION_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [a2n_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [a2n_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [a2n_pkg::PIX_W-1:0]    in_pixel,
    output logic                              push,
    output a2n_pkg::entry_t                   push_entry,
    input  wire a2n_pkg::fifo_stat_t          stat
);

    localparam int DIM_W  = $clog2(MAX_DIMENSION) + 1;
    localparam int CNT_W  = $clog2(MAX_DIMENSION);
    localparam int PROD_W = 2 * DIM_W;
    localparam int ADDR_W = a2n_pkg::ADDR_W;
    localparam int SUM_W  = 17;

    // reset sizes, clipped to the limit like any written size
    localparam int WIDTH_INIT  = (a2n_pkg::WIDTH_RST > MAX_DIMENSION) ?
                                 MAX_DIMENSION : a2n_pkg::WIDTH_RST;
    localparam int HEIGHT_INIT = (a2n_pkg::HEIGHT_RST > MAX_DIMENSION) ?
                                 MAX_DIMENSION : a2n_pkg::HEIGHT_RST;

    // frame geometry
    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [DIM_W-1:0]  cfg_eff;
    logic [PROD_W-1:0] prod;
    logic [ADDR_W-1:0] plane_reg;
    logic              cfg_hit;

    // raster position
    logic [CNT_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] luma_reg, luma_next;
    logic [ADDR_W-1:0] coff_reg, coff_next;
    logic              accept, chroma, last_col, last_px;

    // capture stage
    logic              a_valid_reg, a_valid_next;
    logic [23:0]       a_rgb_reg;
    logic [ADDR_W-1:0] a_luma_reg, a_coff_reg;
    logic              a_chroma_reg, a_last_px_reg;

    logic [SUM_W-1:0]  r_ext, g_ext, b_ext;
    logic [SUM_W-1:0]  y_sum, u_sum, v_sum;

    // zero means one, anything past the limit means the limit
    always_comb begin
        if (cfg_wdata == '0) begin
            cfg_eff = DIM_W'(1);
        end else if (int'(cfg_wdata) > MAX_DIMENSION) begin
            cfg_eff = DIM_W'(MAX_DIMENSION);
        end else begin
            cfg_eff = DIM_W'(cfg_wdata);
        end
    end

    // only a write to a size register restarts the frame
    assign cfg_hit = cfg_wr_en
                   && (cfg_index inside {a2n_pkg::REG_FRAME_WIDTH, a2n_pkg::REG_FRAME_HEIGHT});

    assign prod = PROD_W'(width_reg) * PROD_W'(height_reg);

    assign in_ready = !a_valid_reg || !stat.full;
    assign accept   = in_valid && in_ready;
    assign push     = a_valid_reg && !stat.full;

    assign chroma   = !row_reg[0] && !col_reg[0];
    assign last_col = (DIM_W'(col_reg) + 1'b1) >= width_reg;
    assign last_px  = last_col && ((DIM_W'(row_reg) + 1'b1) >= height_reg);

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        luma_next = luma_reg;
        coff_next = coff_reg;
        if (cfg_hit) begin
            col_next  = '0;
            row_next  = '0;
            luma_next = '0;
            coff_next = '0;
        end else if (accept) begin
            if (last_px) begin
                col_next  = '0;
                row_next  = '0;
                luma_next = '0;
                coff_next = '0;
            end else begin
                luma_next = luma_reg + 1'b1;
                coff_next = chroma ? coff_reg + ADDR_W'(2) : coff_reg;
                if (last_col) begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
    end

    always_comb begin
        a_valid_next = a_valid_reg;
        if (accept) begin
            a_valid_next = 1'b1;
        end else if (push) begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= DIM_W'(WIDTH_INIT);
            height_reg  <= DIM_W'(HEIGHT_INIT);
            plane_reg   <= ADDR_W'(WIDTH_INIT * HEIGHT_INIT);
            col_reg     <= '0;
            row_reg     <= '0;
            luma_reg    <= '0;
            coff_reg    <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    a2n_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_eff;
                    a2n_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_eff;
                    default: ;
                endcase
            end
            plane_reg   <= ADDR_W'(prod);
            col_reg     <= col_next;
            row_reg     <= row_next;
            luma_reg    <= luma_next;
            coff_reg    <= coff_next;
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_rgb_reg     <= in_pixel[23:0];
            a_luma_reg    <= luma_reg;
            a_coff_reg    <= coff_reg;
            a_chroma_reg  <= chroma;
            a_last_px_reg <= last_px;
        end
    end

    // sums stay inside 0..65535, so the shift right by 8 is a byte select
    // and no clamp is ever active
    assign r_ext = SUM_W'(a_rgb_reg[23:16]);
    assign g_ext = SUM_W'(a_rgb_reg[15:8]);
    assign b_ext = SUM_W'(a_rgb_reg[7:0]);

    assign y_sum = r_ext * SUM_W'(a2n_pkg::COEF_YR) + g_ext * SUM_W'(a2n_pkg::COEF_YG)
                 + b_ext * SUM_W'(a2n_pkg::COEF_YB) + SUM_W'(a2n_pkg::ROUND_BIAS);
    assign u_sum = SUM_W'(a2n_pkg::CHROMA_BIAS) + b_ext * SUM_W'(a2n_pkg::COEF_UB)
                 - r_ext * SUM_W'(a2n_pkg::COEF_UR) - g_ext * SUM_W'(a2n_pkg::COEF_UG);
    assign v_sum = SUM_W'(a2n_pkg::CHROMA_BIAS) + r_ext * SUM_W'(a2n_pkg::COEF_VR)
                 - g_ext * SUM_W'(a2n_pkg::COEF_VG) - b_ext * SUM_W'(a2n_pkg::COEF_VB);

    assign push_entry.y_byte      = y_sum[15:8] + a2n_pkg::BYTE_W'(a2n_pkg::LUMA_OFFSET);
    assign push_entry.u_byte      = u_sum[15:8];
    assign push_entry.v_byte      = v_sum[15:8];
    assign push_entry.luma_addr   = a_luma_reg;
    assign push_entry.chroma_addr = plane_reg + a_coff_reg;
    assign push_entry.chroma      = a_chroma_reg;
    assign push_entry.last_px     = a_last_px_reg;

endmodule

`default_nettype wire

/* src/a2n_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module a2n_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire a2n_pkg::entry_t            head_entry,
    input  wire a2n_pkg::fifo_stat_t        stat,
    output logic                            pop,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [a2n_pkg::BYTE_W-1:0]      out_byte,
    output logic [a2n_pkg::ADDR_W-1:0]      out_address,
    output a2n_pkg::kind_t                  out_kind,
    output logic                            out_last_px,
    output logic                            out_done
);

    a2n_pkg::kind_t              phase_reg, phase_next;
    logic                        valid_reg, valid_next;
    logic [a2n_pkg::BYTE_W-1:0]  byte_reg, byte_next;
    logic [a2n_pkg::ADDR_W-1:0]  addr_reg, addr_next;
    a2n_pkg::kind_t              kind_reg, kind_next;
    logic                        last_reg, last_next;
    logic                        done_reg, done_next;
    logic                        load;

    assign load = !stat.empty && (!valid_reg || out_ready);

    always_comb begin
        phase_next = phase_reg;
        valid_next = valid_reg && !out_ready;
        byte_next  = byte_reg;
        addr_next  = addr_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            kind_next  = phase_reg;
            case (phase_reg)
                a2n_pkg::KIND_Y: begin
                    byte_next  = head_entry.y_byte;
                    addr_next  = head_entry.luma_addr;
                    last_next  = !head_entry.chroma;
                    done_next  = !head_entry.chroma && head_entry.last_px;
                    pop        = !head_entry.chroma;
                    phase_next = head_entry.chroma ? a2n_pkg::KIND_V : a2n_pkg::KIND_Y;
                end
                a2n_pkg::KIND_V: begin
                    byte_next  = head_entry.v_byte;
                    addr_next  = head_entry.chroma_addr;
                    last_next  = 1'b0;
                    done_next  = 1'b0;
                    phase_next = a2n_pkg::KIND_U;
                end
                a2n_pkg::KIND_U: begin
                    byte_next  = head_entry.u_byte;
                    addr_next  = head_entry.chroma_addr + 1'b1;
                    last_next  = 1'b1;
                    done_next  = head_entry.last_px;
                    pop        = 1'b1;
                    phase_next = a2n_pkg::KIND_Y;
                end
                default: begin
                    valid_next = 1'b0;
                    phase_next = a2n_pkg::KIND_Y;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= a2n_pkg::KIND_Y;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        addr_reg <= addr_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign out_address = addr_reg;
    assign out_kind    = kind_reg;
    assign out_last_px = last_reg;
    assign out_done    = done_reg;

endmodule

`default_nettype wire

/* src/argb_to_nv21_converter_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// ARGB to NV21 converter. Pixels of a frame come in raster order, one 32-bit
// ARGB word per input beat (alpha ignored); each is turned into BT.601
// studio-range Y, V and U bytes and leaves as address/byte beats for an NV21
// buffer: every pixel gives its Y byte at the next luma address, and a pixel
// on an even row and even column also gives V then U at the next two chroma
// addresses, the chroma plane starting at width*height. The output register
// carries one byte per cycle while the sink is ready: a pixel gives one byte,
// or three on an even row and even column; a frame of even width and height
// averages 1.5 bytes per pixel, while odd sizes and single-row frames give
// more, up to three bytes per pixel for a 1x1 frame. Input beats are taken
// one per cycle while the pixel queue has room. Writing either size register
// restarts the frame; write only while the block is idle; the next pixel may
// follow in the cycle right after the write. A write to any other index does
// nothing. A size of zero counts as one, a size above MAX_DIMENSION as
// MAX_DIMENSION.
module argb_to_nv21_converter_top #(
    parameter int MAX_DIMENSION = a2n_pkg::MAX_DIMENSION_DEF,
    parameter int FIFO_DEPTH    = a2n_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    // size registers: index 0 frame_width, index 1 frame_height
    input  wire logic                             cfg_wr_en,
    input  wire logic [a2n_pkg::IDX_W-1:0]        cfg_index,
    input  wire logic [a2n_pkg::CFG_W-1:0]        cfg_wdata,

    // pixel input
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [a2n_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // argb_pixel [31:0]

    // byte output
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [a2n_pkg::M_TDATA_W-1:0]         m_axis_tdata,  // out_byte [7:0],
                                                                 // out_address [32:8],
                                                                 // zero [39:33]
    output logic [a2n_pkg::M_TUSER_W-1:0]         m_axis_tuser,  // sample_kind [1:0],
                                                                 // last_of_pixel [2]
    output logic                                  m_axis_tlast   // frame_done
);

    // front to queue
    logic                        push;
    a2n_pkg::entry_t             push_entry;
    // queue to back
    logic                        pop;
    a2n_pkg::entry_t             head_entry;
    a2n_pkg::fifo_stat_t         stat;
    // back outputs
    logic [a2n_pkg::BYTE_W-1:0]  out_byte;
    logic [a2n_pkg::ADDR_W-1:0]  out_address;
    a2n_pkg::kind_t              out_kind;
    logic                        out_last_px;
    logic                        out_done;

    // front: frame counters, address bookkeeping and color conversion
    a2n_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_pixel   (s_axis_tdata),
        .push       (push),
        .push_entry (push_entry),
        .stat       (stat)
    );

    // converted pixels waiting for the byte serializer
    a2n_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .stat       (stat)
    );

    // back: one output beat per cycle while the sink is ready and a pixel waits, Y then optional V and U
    a2n_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_entry  (head_entry),
        .stat        (stat),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_byte    (out_byte),
        .out_address (out_address),
        .out_kind    (out_kind),
        .out_last_px (out_last_px),
        .out_done    (out_done)
    );

    // output packing
    assign m_axis_tdata = {7'd0, out_address, out_byte};
    assign m_axis_tuser = {out_last_px, out_kind};
    assign m_axis_tlast = out_done;

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && stat.full))
        else $error("pixel queue overflow");

    // frame end only on the closing byte of a pixel
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[2])
        else $error("frame_done without last_of_pixel");

    // a V byte that is taken is followed right away by its U byte
    a_v_then_u: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && (m_axis_tuser[1:0] == a2n_pkg::KIND_V)
        |=> m_axis_tvalid && (m_axis_tuser[1:0] == a2n_pkg::KIND_U))
        else $error("V byte not followed by U byte");

    // U lands right after V in the chroma plane
    a_u_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && (m_axis_tuser[1:0] == a2n_pkg::KIND_V)
        |=> m_axis_tdata[32:8] == $past(m_axis_tdata[32:8]) + 25'd1)
        else $error("U address does not follow V address");

endmodule

`default_nettype wire

/* tb/tb_argb_to_nv21_converter_top.sv */
`timescale 1ns / 1ps

module tb_argb_to_nv21_converter_top;

    // frame geometry as the block sees it
    localparam int SIZE_LIMIT      = 4096;
    localparam int WIDTH_AT_RESET  = 640;
    localparam int HEIGHT_AT_RESET = 480;

    // index past the two size registers, must be ignored
    localparam logic [a2n_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

    // random part: idle phases, each split in two halves
    localparam int PHASES         = 4;
    localparam int ITEMS_PER_HALF = 31;

    // what happens between the two halves of a phase
    typedef enum int {
        MID_PAUSE,
        MID_SPARE_WRITE,
        MID_RESIZE
    } mid_action_t;

    // one expected output byte beat
    typedef struct {
        logic [a2n_pkg::BYTE_W-1:0] out_byte;
        logic [a2n_pkg::ADDR_W-1:0] out_address;
        a2n_pkg::kind_t             sample_kind;
        logic                       last_of_pixel;
        logic                       frame_done;
    } nv21_beat_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #4 aclk = ~aclk;

    // size register write port
    logic                      cfg_wr_en = 1'b0;
    logic [a2n_pkg::IDX_W-1:0] cfg_index = '0;
    logic [a2n_pkg::CFG_W-1:0] cfg_wdata = '0;

    // pixel stream into the block
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [a2n_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;

    // byte stream out of the block
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [a2n_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [a2n_pkg::M_TUSER_W-1:0] m_axis_tuser;
    logic                          m_axis_tlast;

    argb_to_nv21_converter_top #(
        .MAX_DIMENSION (SIZE_LIMIT)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // argb_pixel [31:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // out_byte [7:0], out_address [32:8], zero [39:33]
        .m_axis_tuser  (m_axis_tuser),   // sample_kind [1:0], last_of_pixel [2]
        .m_axis_tlast  (m_axis_tlast)    // frame_done
    );

    // pixels waiting for the driver, bytes waiting for the monitor
    logic [a2n_pkg::S_TDATA_W-1:0] pixel_queue [$];
    nv21_beat_t                    expected_bytes [$];

    // idle odds in percent, changed only between phases
    int unsigned send_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;

    int   mismatch_count = 0;
    logic pix_taken      = 1'b0;

    // own copy of the size registers and the frame position
    logic [a2n_pkg::CFG_W-1:0]  width_reg  = a2n_pkg::CFG_W'(WIDTH_AT_RESET);
    logic [a2n_pkg::CFG_W-1:0]  height_reg = a2n_pkg::CFG_W'(HEIGHT_AT_RESET);
    logic [11:0]                col_cnt;
    logic [11:0]                row_cnt;
    logic [a2n_pkg::ADDR_W-1:0] luma_addr;
    logic [a2n_pkg::ADDR_W-1:0] chroma_addr;

    // zero counts as one, oversize is clipped to the limit
    function automatic int effective_size(input logic [a2n_pkg::CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > SIZE_LIMIT)
            return SIZE_LIMIT;
        return int'(v);
    endfunction

    function automatic void restart_frame();
        col_cnt     = '0;
        row_cnt     = '0;
        luma_addr   = '0;
        chroma_addr = a2n_pkg::ADDR_W'(effective_size(width_reg) * effective_size(height_reg));
    endfunction

    function automatic logic [a2n_pkg::BYTE_W-1:0] clamp_byte(input int v);
        if (v < 0)
            return '0;
        if (v > 255)
            return '1;
        return a2n_pkg::BYTE_W'(v);
    endfunction

    function automatic void add_beat(input logic [a2n_pkg::BYTE_W-1:0] b,
                                     input logic [a2n_pkg::ADDR_W-1:0] a,
                                     input a2n_pkg::kind_t k, input logic last_b,
                                     input logic done_b);
        nv21_beat_t beat;
        beat.out_byte      = b;
        beat.out_address   = a;
        beat.sample_kind   = k;
        beat.last_of_pixel = last_b;
        beat.frame_done    = done_b;
        expected_bytes.push_back(beat);
    endfunction

    // bt.601 studio range conversion of one pixel, plus the frame bookkeeping
    function automatic void convert_pixel(input logic [a2n_pkg::S_TDATA_W-1:0] px);
        int r, g, b, w, h;
        logic [a2n_pkg::BYTE_W-1:0] y_b, u_b, v_b;
        logic use_chroma, last_col, last_px;
        r = int'(px[23:16]);
        g = int'(px[15:8]);
        b = int'(px[7:0]);
        w = effective_size(width_reg);
        h = effective_size(height_reg);
        y_b = clamp_byte(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
        // 32768 lifts the sum above zero so the shift is a plain floor
        u_b = clamp_byte((-38 * r - 74 * g + 112 * b + 128 + 32768) >>> 8);
        v_b = clamp_byte((112 * r - 94 * g - 18 * b + 128 + 32768) >>> 8);
        use_chroma = !row_cnt[0] && !col_cnt[0];
        last_col   = (int'(col_cnt) + 1) >= w;
        last_px    = last_col && ((int'(row_cnt) + 1) >= h);
        if (use_chroma) begin
            add_beat(y_b, luma_addr, a2n_pkg::KIND_Y, 1'b0, 1'b0);
            add_beat(v_b, chroma_addr, a2n_pkg::KIND_V, 1'b0, 1'b0);
            add_beat(u_b, chroma_addr + 1'b1, a2n_pkg::KIND_U, 1'b1, last_px);
            chroma_addr = chroma_addr + 2'd2;
        end else begin
            add_beat(y_b, luma_addr, a2n_pkg::KIND_Y, 1'b1, last_px);
        end
        luma_addr = luma_addr + 1'b1;
        if (last_px) begin
            restart_frame();
        end else if (last_col) begin
            col_cnt = '0;
            row_cnt = row_cnt + 1'b1;
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
    endfunction

    function automatic void check_field(input string name, input int expected_v,
                                        input int actual_v);
        if (expected_v != actual_v) begin
            $error("%s: expected %0d, actual %0d", name, expected_v, actual_v);
            mismatch_count++;
        end
    endfunction

    // mostly tiny frames so that frame ends come often, now and then an extreme
    function automatic logic [a2n_pkg::CFG_W-1:0] pick_size();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return '1;
            default: return a2n_pkg::CFG_W'($urandom_range(9, 1));
        endcase
    endfunction

    // size register write, only called with the block idle
    task automatic write_reg(input logic [a2n_pkg::IDX_W-1:0] idx,
                             input logic [a2n_pkg::CFG_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            a2n_pkg::REG_FRAME_WIDTH: begin
                width_reg = value;
                restart_frame();
            end
            a2n_pkg::REG_FRAME_HEIGHT: begin
                height_reg = value;
                restart_frame();
            end
            default: ;
        endcase
        // chroma base is recomputed after the write
        repeat (3) @(negedge aclk);
    endtask

    // sender holds off until every byte has come out, then idles on
    task automatic wait_for_idle();
        do
            @(posedge aclk);
        while (pixel_queue.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    // pixel driver: next beat goes out once the current one was taken
    always @(negedge aclk) begin : pixel_driver
        logic                          nxt_valid;
        logic [a2n_pkg::S_TDATA_W-1:0] nxt_data;
        nxt_valid = s_axis_tvalid;
        nxt_data  = s_axis_tdata;
        if (aresetn && (!s_axis_tvalid || pix_taken)) begin
            nxt_valid = 1'b0;
            if (pixel_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                nxt_data  = pixel_queue.pop_front();
                nxt_valid = 1'b1;
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata  <= nxt_data;
    end

    // byte sink with random stalls
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end

    // monitor: predict on every taken pixel, check every taken byte
    always @(posedge aclk) begin : byte_monitor
        nv21_beat_t exp_b;
        if (!aresetn) begin
            pix_taken <= 1'b0;
        end else begin
            pix_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                convert_pixel(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected byte beat: out_address %0d, out_byte %0d",
                           m_axis_tdata[32:8], m_axis_tdata[7:0]);
                    mismatch_count++;
                end else begin
                    exp_b = expected_bytes.pop_front();
                    check_field("out_byte", int'(exp_b.out_byte), int'(m_axis_tdata[7:0]));
                    check_field("out_address", int'(exp_b.out_address),
                                int'(m_axis_tdata[32:8]));
                    check_field("sample_kind", int'(exp_b.sample_kind),
                                int'(m_axis_tuser[1:0]));
                    check_field("last_of_pixel", int'(exp_b.last_of_pixel),
                                int'(m_axis_tuser[2]));
                    check_field("frame_done", int'(exp_b.frame_done), int'(m_axis_tlast));
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        logic [a2n_pkg::S_TDATA_W-1:0] px;
        mid_action_t                   act;
        restart_frame();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(negedge aclk);

        // channel extremes at the reset size, alpha alone must change nothing
        pixel_queue.push_back(32'h0000_0000);
        pixel_queue.push_back(32'hFFFF_FFFF);
        pixel_queue.push_back(32'h00FF_0000);
        pixel_queue.push_back(32'h0000_FF00);
        pixel_queue.push_back(32'h0000_00FF);
        pixel_queue.push_back(32'hFF00_0000);
        wait_for_idle();

        // 3x3 frame: odd width gives chroma on the last column, frame wraps
        write_reg(a2n_pkg::REG_FRAME_WIDTH, 13'd3);
        write_reg(a2n_pkg::REG_FRAME_HEIGHT, 13'd3);
        repeat (4) pixel_queue.push_back($urandom);
        wait_for_idle();
        // write past the size registers mid frame, frame must carry on
        write_reg(REG_UNUSED, '1);
        repeat (6) pixel_queue.push_back($urandom);
        wait_for_idle();

        // zero sizes count as a 1x1 frame, every pixel ends a frame
        write_reg(a2n_pkg::REG_FRAME_WIDTH, '0);
        write_reg(a2n_pkg::REG_FRAME_HEIGHT, '0);
        repeat (3) pixel_queue.push_back($urandom);
        wait_for_idle();

        // oversize width clipped to the limit
        write_reg(a2n_pkg::REG_FRAME_WIDTH, '1);
        write_reg(a2n_pkg::REG_FRAME_HEIGHT, 13'd2);
        repeat (2) pixel_queue.push_back($urandom);
        wait_for_idle();

        // largest frame, chroma plane starting at 4096*4096 in the upper half of the address range
        write_reg(a2n_pkg::REG_FRAME_WIDTH, a2n_pkg::CFG_W'(SIZE_LIMIT));
        write_reg(a2n_pkg::REG_FRAME_HEIGHT, '1);
        repeat (2) pixel_queue.push_back($urandom);
        wait_for_idle();

        // random part: no idling, slow sender, slow sink, both a little
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 75;
                    sink_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 75;
                end
                default: begin
                    send_idle_pct  = 22;
                    sink_stall_pct = 22;
                end
            endcase
            write_reg(a2n_pkg::REG_FRAME_WIDTH, pick_size());
            write_reg(a2n_pkg::REG_FRAME_HEIGHT, pick_size());
            for (int half = 0; half < 2; half++) begin
                repeat (ITEMS_PER_HALF) begin
                    px = $urandom;
                    case ($urandom_range(7, 0))
                        0:       px = {32{px[0]}};
                        // each color channel saturated at zero or full
                        1:       px = {px[31:24], {8{px[0]}}, {8{px[1]}}, {8{px[2]}}};
                        default: ;
                    endcase
                    pixel_queue.push_back(px);
                end
                wait_for_idle();
                if (half == 0) begin
                    // first phase always holds off mid frame with no write
                    act = (p == 0) ? MID_PAUSE : mid_action_t'($urandom_range(2, 0));
                    case (act)
                        MID_SPARE_WRITE: write_reg(REG_UNUSED, a2n_pkg::CFG_W'($urandom));
                        MID_RESIZE:      write_reg(a2n_pkg::REG_FRAME_WIDTH, pick_size());
                        default: ;
                    endcase
                end
            end
        end

        wait_for_idle();
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
